>>> hw/rtl/mac_keyed_peer_table_defines.svh
// assertion macros used by the checker file
`ifndef MAC_KEYED_PEER_TABLE_DEFINES_SVH
`define MAC_KEYED_PEER_TABLE_DEFINES_SVH

// same-cycle implication, off during reset
`define MKPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mkpt assertion failed");

// next-cycle implication, off during reset
`define MKPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mkpt assertion failed");

`endif

>>> hw/rtl/mkpt_pkg.sv
// types, codes and helpers for the peer table
package mkpt_pkg;

    localparam int MAC_W   = 48;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;

    localparam logic [1:0] REQ_UPSERT = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_GET    = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam logic [1:0] EMIT_NONE  = 2'd0;
    localparam logic [1:0] EMIT_READ  = 2'd1;
    localparam logic [1:0] EMIT_WRITE = 2'd2;
    localparam logic [1:0] EMIT_CODE  = 2'd3;

    localparam logic CFG_MAC       = 1'b0;
    localparam logic CFG_MAC_VALID = 1'b1;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [BYTE_W-1:0] active_profile;
        logic [BYTE_W-1:0] default_profile;
        logic [BYTE_W-1:0] dev_state;
        logic [MAC_W-1:0]  owner_mac;
        logic              reachable;
    } entry_t;

    typedef struct packed {
        logic       load;
        logic       scan;
        logic       rd_idx;
        logic       wr;
        logic       wr_append;
        logic       clear;
        logic [1:0] emit;
        logic [1:0] code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       hit;
        logic       miss;
        logic       full;
        logic       idx_ok;
    } sts_t;

    function automatic logic owned_other(
        input logic [MAC_W-1:0] owner,
        input logic [MAC_W-1:0] cmac,
        input logic             cvalid
    );
        logic res;
        res = (owner != '0) && (!cvalid || (owner != cmac));
        return res;
    endfunction

endpackage

>>> hw/rtl/mkpt_ctrl.sv
// request sequencer for the peer table
module mkpt_ctrl
    import mkpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_GET  = 3'd3;
    localparam logic [2:0] S_GETW = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.req) inside
                    REQ_UPSERT, REQ_FIND: state_next = S_SCAN;
                    REQ_GET:              state_next = S_GET;
                    default:
                    begin
                        cmd.clear  = 1'b1;
                        cmd.emit   = EMIT_CODE;
                        cmd.code   = ST_OK;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    if (sts.req == REQ_UPSERT)
                    begin
                        cmd.wr   = 1'b1;
                        cmd.emit = EMIT_WRITE;
                    end
                    else
                    begin
                        cmd.emit = EMIT_READ;
                    end
                    state_next = S_IDLE;
                end
                else if (sts.miss)
                begin
                    if (sts.req != REQ_UPSERT)
                    begin
                        cmd.emit = EMIT_CODE;
                        cmd.code = ST_MISS;
                    end
                    else if (sts.full)
                    begin
                        cmd.emit = EMIT_CODE;
                        cmd.code = ST_FULL;
                    end
                    else
                    begin
                        cmd.wr        = 1'b1;
                        cmd.wr_append = 1'b1;
                        cmd.emit      = EMIT_WRITE;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_GET:
            begin
                if (sts.idx_ok)
                begin
                    cmd.rd_idx = 1'b1;
                    state_next = S_GETW;
                end
                else
                begin
                    cmd.emit   = EMIT_CODE;
                    cmd.code   = ST_MISS;
                    state_next = S_IDLE;
                end
            end
            S_GETW:
            begin
                cmd.emit   = EMIT_READ;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> hw/rtl/mkpt_datapath.sv
// slot memory, scan pointer, count and result registers
module mkpt_datapath
    import mkpt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [MAC_W-1:0]  cfg_data,
    input  logic [1:0]        req_type,
    input  logic [MAC_W-1:0]  key_mac,
    input  logic [BYTE_W-1:0] new_active_profile,
    input  logic [BYTE_W-1:0] new_default_profile,
    input  logic [BYTE_W-1:0] new_dev_state,
    input  logic [MAC_W-1:0]  new_owner_mac,
    input  logic [IDX_W-1:0]  entry_index,
    output logic              done,
    output logic [1:0]        status,
    output logic [IDX_W-1:0]  hit_index,
    output logic [MAC_W-1:0]  entry_mac,
    output logic [BYTE_W-1:0] entry_active_profile,
    output logic [BYTE_W-1:0] entry_default_profile,
    output logic [BYTE_W-1:0] entry_dev_state,
    output logic [MAC_W-1:0]  entry_owner_mac,
    output logic              entry_reachable,
    output logic              owned_by_other,
    output logic [CNT_W-1:0]  count_now
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    entry_t mem [MAX_ENTRIES];

    logic [1:0]        req_reg;
    logic [MAC_W-1:0]  key_reg;
    logic [BYTE_W-1:0] act_reg;
    logic [BYTE_W-1:0] def_reg;
    logic [BYTE_W-1:0] dev_reg;
    logic [MAC_W-1:0]  own_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [MAC_W-1:0]  cmac_reg;
    logic              cvalid_reg;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     ptr_reg;
    logic [CW-1:0]     ptr_next;
    logic              rd_vld_reg;
    logic              rd_vld_next;
    logic [AW-1:0]     rd_addr_reg;
    entry_t            rd_data_reg;

    logic              ptr_lt;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_entry;

    logic              done_reg;
    logic              done_next;
    logic [1:0]        res_status_reg;
    logic [1:0]        res_status_next;
    logic [IDX_W-1:0]  res_index_reg;
    logic [IDX_W-1:0]  res_index_next;
    entry_t            res_entry_reg;
    entry_t            res_entry_next;
    logic              res_other_reg;
    logic              res_other_next;
    logic [CNT_W-1:0]  res_count_reg;

    assign ptr_lt  = (ptr_reg < count_reg);
    assign rd_en   = (cmd.scan && ptr_lt) || cmd.rd_idx;
    assign rd_addr = cmd.rd_idx ? AW'(idx_reg) : AW'(ptr_reg);
    assign wr_addr = cmd.wr_append ? AW'(count_reg) : rd_addr_reg;

    always_comb
    begin
        wr_entry.mac             = key_reg;
        wr_entry.active_profile  = act_reg;
        wr_entry.default_profile = def_reg;
        wr_entry.dev_state       = dev_reg;
        wr_entry.owner_mac       = own_reg;
        wr_entry.reachable       = 1'b1;
    end

    always_comb
    begin
        sts.req    = req_reg;
        sts.hit    = rd_vld_reg && (rd_data_reg.mac == key_reg);
        sts.miss   = !rd_vld_reg && !ptr_lt;
        sts.full   = (count_reg >= MAX_CNT);
        sts.idx_ok = (IW'(idx_reg) < IW'(count_reg));
    end

    always_comb
    begin
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.wr && cmd.wr_append)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else
        begin
            count_next = count_reg;
        end

        if (cmd.load)
        begin
            ptr_next    = '0;
            rd_vld_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            ptr_next    = ptr_lt ? CW'(ptr_reg + 1'b1) : ptr_reg;
            rd_vld_next = ptr_lt;
        end
        else
        begin
            ptr_next    = ptr_reg;
            rd_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        done_next       = 1'b1;
        res_status_next = ST_OK;
        res_index_next  = '0;
        res_entry_next  = '0;
        res_other_next  = 1'b0;
        case (cmd.emit)
            EMIT_READ:
            begin
                res_index_next = IDX_W'(rd_addr_reg);
                res_entry_next = rd_data_reg;
                res_other_next = owned_other(rd_data_reg.owner_mac, cmac_reg, cvalid_reg);
            end
            EMIT_WRITE:
            begin
                res_index_next = IDX_W'(wr_addr);
                res_entry_next = wr_entry;
                res_other_next = owned_other(own_reg, cmac_reg, cvalid_reg);
            end
            EMIT_CODE:
            begin
                res_status_next = cmd.code;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
            cmac_reg   <= '0;
            cvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            rd_vld_reg <= rd_vld_next;
            done_reg   <= done_next;
            if (cfg_we && (cfg_index == CFG_MAC))
            begin
                cmac_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_MAC_VALID))
            begin
                cvalid_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            key_reg <= key_mac;
            act_reg <= new_active_profile;
            def_reg <= new_default_profile;
            dev_reg <= new_dev_state;
            own_reg <= new_owner_mac;
            idx_reg <= entry_index;
        end
        if (cmd.wr)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (done_next)
        begin
            res_status_reg <= res_status_next;
            res_index_reg  <= res_index_next;
            res_entry_reg  <= res_entry_next;
            res_other_reg  <= res_other_next;
            res_count_reg  <= CNT_W'(count_next);
        end
    end

    assign done                  = done_reg;
    assign status                = res_status_reg;
    assign hit_index             = res_index_reg;
    assign entry_mac             = res_entry_reg.mac;
    assign entry_active_profile  = res_entry_reg.active_profile;
    assign entry_default_profile = res_entry_reg.default_profile;
    assign entry_dev_state       = res_entry_reg.dev_state;
    assign entry_owner_mac       = res_entry_reg.owner_mac;
    assign entry_reachable       = res_entry_reg.reachable;
    assign owned_by_other        = res_other_reg;
    assign count_now             = res_count_reg;

endmodule

>>> hw/rtl/mac_keyed_peer_table.sv
// top level of the MAC-keyed peer table
// A request is taken on a clock edge with start high and busy low, and its one result beat
// shows on the result ports for a single cycle with done high; the receiver cannot stall, so
// it must take every beat as it comes. Find and upsert walk the occupied slots through the
// single read port of the slot memory, one slot per cycle, so they take longer as the table
// fills; get reads one slot by its index. The slot memory is not cleared after reset: only
// slots below the entry count are ever read.
module mac_keyed_peer_table
    import mkpt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [MAC_W-1:0]  cfg_data,
    input  logic [1:0]        req_type,
    input  logic [MAC_W-1:0]  key_mac,
    input  logic [BYTE_W-1:0] new_active_profile,
    input  logic [BYTE_W-1:0] new_default_profile,
    input  logic [BYTE_W-1:0] new_dev_state,
    input  logic [MAC_W-1:0]  new_owner_mac,
    input  logic [IDX_W-1:0]  entry_index,
    output logic              done,
    output logic [1:0]        status,
    output logic [IDX_W-1:0]  hit_index,
    output logic [MAC_W-1:0]  entry_mac,
    output logic [BYTE_W-1:0] entry_active_profile,
    output logic [BYTE_W-1:0] entry_default_profile,
    output logic [BYTE_W-1:0] entry_dev_state,
    output logic [MAC_W-1:0]  entry_owner_mac,
    output logic              entry_reachable,
    output logic              owned_by_other,
    output logic [CNT_W-1:0]  count_now
);

    cmd_t cmd;
    sts_t sts;

    mkpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    mkpt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .sts                   (sts),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .req_type              (req_type),
        .key_mac               (key_mac),
        .new_active_profile    (new_active_profile),
        .new_default_profile   (new_default_profile),
        .new_dev_state         (new_dev_state),
        .new_owner_mac         (new_owner_mac),
        .entry_index           (entry_index),
        .done                  (done),
        .status                (status),
        .hit_index             (hit_index),
        .entry_mac             (entry_mac),
        .entry_active_profile  (entry_active_profile),
        .entry_default_profile (entry_default_profile),
        .entry_dev_state       (entry_dev_state),
        .entry_owner_mac       (entry_owner_mac),
        .entry_reachable       (entry_reachable),
        .owned_by_other        (owned_by_other),
        .count_now             (count_now)
    );

endmodule

>>> hw/rtl/mkpt_checker.sv
// port-level checks for the peer table, bound to the top level
`include "mac_keyed_peer_table_defines.svh"

module mkpt_checker
    import mkpt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [1:0]        status,
    input logic [IDX_W-1:0]  hit_index,
    input logic [MAC_W-1:0]  entry_mac,
    input logic              owned_by_other,
    input logic [CNT_W-1:0]  count_now
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT =
        (CW > CNT_W) ? {CNT_W{1'b1}} : CNT_W'(MAX_ENTRIES);

    `MKPT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    `MKPT_ASSERT_NEXT(a_beat_single, clk, rst_n, done, !done)
    `MKPT_ASSERT_IMPLY(a_beat_code, clk, rst_n, done, status == ST_OK || status == ST_FULL || status == ST_MISS)
    `MKPT_ASSERT_IMPLY(a_fail_zero, clk, rst_n, done && status != ST_OK, hit_index == '0 && entry_mac == '0 && !owned_by_other)
    `MKPT_ASSERT_IMPLY(a_count_cap, clk, rst_n, done, count_now <= CNT_LIMIT)

endmodule

bind mac_keyed_peer_table mkpt_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_mkpt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .hit_index      (hit_index),
    .entry_mac      (entry_mac),
    .owned_by_other (owned_by_other),
    .count_now      (count_now)
);

>>> test/tb_mac_keyed_peer_table.sv
// testbench for mac_keyed_peer_table: directed and random requests checked by a scoreboard
module tb_mac_keyed_peer_table;
    import mkpt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int PHASE_ITEMS = 325;
    localparam int POOL_SIZE   = 24;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]        kind;
        logic [MAC_W-1:0]  peer;
        logic [BYTE_W-1:0] active_profile;
        logic [BYTE_W-1:0] default_profile;
        logic [BYTE_W-1:0] dev_state;
        logic [MAC_W-1:0]  owner;
        logic [IDX_W-1:0]  index;
    } request_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] hit_index;
        entry_t           entry;
        logic             owned_by_other;
        logic [CNT_W-1:0] count_now;
    } reply_t;

    class peer_table_mirror;
        entry_t           slots [TABLE_DEPTH];
        int               occupied = 0;
        logic [MAC_W-1:0] own_mac = '0;
        logic             own_mac_set = 1'b0;
        reply_t           awaited [$];
        int               errors = 0;
        int               reported = 0;
        int               n_upsert = 0;
        int               n_find = 0;
        int               n_get = 0;
        int               n_clear = 0;
        int               n_full = 0;
        int               n_miss = 0;

        function void write_reg(logic idx, logic [MAC_W-1:0] data);
            if (idx == CFG_MAC)
                own_mac = data;
            else
                own_mac_set = data[0];
        endfunction

        function reply_t slot_reply(int i);
            reply_t rp;
            rp = '0;
            rp.status = ST_OK;
            rp.hit_index = IDX_W'(i);
            rp.entry = slots[i];
            rp.owned_by_other = (slots[i].owner_mac != '0) &&
                                (!own_mac_set || slots[i].owner_mac != own_mac);
            return rp;
        endfunction

        function void note_request(request_t rq);
            reply_t rp;
            int     slot;
            bit     found;
            rp = '0;
            slot = 0;
            found = 1'b0;
            if (rq.kind == REQ_UPSERT || rq.kind == REQ_FIND)
            begin
                for (int i = 0; i < occupied && !found; i++)
                begin
                    if (slots[i].mac == rq.peer)
                    begin
                        slot = i;
                        found = 1'b1;
                    end
                end
            end
            case (rq.kind)
                REQ_UPSERT:
                begin
                    n_upsert++;
                    if (!found && occupied >= TABLE_DEPTH)
                    begin
                        rp.status = ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        if (!found)
                        begin
                            slot = occupied;
                            slots[slot].mac = rq.peer;
                            occupied++;
                        end
                        slots[slot].active_profile = rq.active_profile;
                        slots[slot].default_profile = rq.default_profile;
                        slots[slot].dev_state = rq.dev_state;
                        slots[slot].owner_mac = rq.owner;
                        slots[slot].reachable = 1'b1;
                        rp = slot_reply(slot);
                    end
                end
                REQ_FIND:
                begin
                    n_find++;
                    if (found)
                        rp = slot_reply(slot);
                    else
                    begin
                        rp.status = ST_MISS;
                        n_miss++;
                    end
                end
                REQ_GET:
                begin
                    n_get++;
                    if (int'(rq.index) < occupied)
                        rp = slot_reply(int'(rq.index));
                    else
                    begin
                        rp.status = ST_MISS;
                        n_miss++;
                    end
                end
                default:
                begin
                    n_clear++;
                    occupied = 0;
                end
            endcase
            rp.count_now = CNT_W'(occupied);
            awaited.push_back(rp);
        endfunction

        function string describe(reply_t r);
            return $sformatf("st=%0d idx=%0d mac=%h ap=%h dp=%h ds=%h own=%h reach=%b oth=%b cnt=%0d",
                             r.status, r.hit_index, r.entry.mac, r.entry.active_profile,
                             r.entry.default_profile, r.entry.dev_state,
                             r.entry.owner_mac, r.entry.reachable, r.owned_by_other,
                             r.count_now);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected reply beat: %s", describe(got));
                end
            end
            else
            begin
                want = awaited.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("reply mismatch, expected %s", describe(want));
                        $display("                actual   %s", describe(got));
                    end
                end
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              cfg_we = 1'b0;
    logic              cfg_index = CFG_MAC;
    logic [MAC_W-1:0]  cfg_data = '0;
    logic [1:0]        req_type = REQ_UPSERT;
    logic [MAC_W-1:0]  key_mac = '0;
    logic [BYTE_W-1:0] new_active_profile = '0;
    logic [BYTE_W-1:0] new_default_profile = '0;
    logic [BYTE_W-1:0] new_dev_state = '0;
    logic [MAC_W-1:0]  new_owner_mac = '0;
    logic [IDX_W-1:0]  entry_index = '0;
    logic              done;
    logic [1:0]        status;
    logic [IDX_W-1:0]  hit_index;
    logic [MAC_W-1:0]  entry_mac;
    logic [BYTE_W-1:0] entry_active_profile;
    logic [BYTE_W-1:0] entry_default_profile;
    logic [BYTE_W-1:0] entry_dev_state;
    logic [MAC_W-1:0]  entry_owner_mac;
    logic              entry_reachable;
    logic              owned_by_other;
    logic [CNT_W-1:0]  count_now;

    peer_table_mirror mirror = new;
    logic [MAC_W-1:0] ctrl_mac = '0;
    int               settings_used = 0;
    int               idle_cycles = 0;

    mac_keyed_peer_table #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .req_type             (req_type),
        .key_mac              (key_mac),
        .new_active_profile   (new_active_profile),
        .new_default_profile  (new_default_profile),
        .new_dev_state        (new_dev_state),
        .new_owner_mac        (new_owner_mac),
        .entry_index          (entry_index),
        .done                 (done),
        .status               (status),
        .hit_index            (hit_index),
        .entry_mac            (entry_mac),
        .entry_active_profile (entry_active_profile),
        .entry_default_profile(entry_default_profile),
        .entry_dev_state      (entry_dev_state),
        .entry_owner_mac      (entry_owner_mac),
        .entry_reachable      (entry_reachable),
        .owned_by_other       (owned_by_other),
        .count_now            (count_now)
    );

    always #4 clk = ~clk;

    // result beat capture
    always @(posedge clk)
    begin
        reply_t got;
        if (rst_n && done)
        begin
            got = {status, hit_index, entry_mac, entry_active_profile, entry_default_profile,
                   entry_dev_state, entry_owner_mac, entry_reachable, owned_by_other,
                   count_now};
            mirror.check_reply(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        return wide[MAC_W-1:0];
    endfunction

    function automatic logic [MAC_W-1:0] pick_owner(logic [MAC_W-1:0] alt);
        logic [MAC_W-1:0] owner;
        case ($urandom_range(0, 3))
            0: owner = '0;
            1: owner = ctrl_mac;
            2: owner = rand_mac();
            default: owner = alt;
        endcase
        return owner;
    endfunction

    function automatic request_t make_req(logic [1:0] kind, logic [MAC_W-1:0] peer,
                                          logic [BYTE_W-1:0] ap, logic [BYTE_W-1:0] dp,
                                          logic [BYTE_W-1:0] ds, logic [MAC_W-1:0] owner,
                                          logic [IDX_W-1:0] index);
        request_t rq;
        rq.kind = kind;
        rq.peer = peer;
        rq.active_profile = ap;
        rq.default_profile = dp;
        rq.dev_state = ds;
        rq.owner = owner;
        rq.index = index;
        return rq;
    endfunction

    task automatic drive_request(request_t rq, int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type <= rq.kind;
        key_mac <= rq.peer;
        new_active_profile <= rq.active_profile;
        new_default_profile <= rq.default_profile;
        new_dev_state <= rq.dev_state;
        new_owner_mac <= rq.owner;
        entry_index <= rq.index;
        start <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        mirror.note_request(rq);
    endtask

    // drop start and wait for the table to go quiet
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (mirror.awaited.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [MAC_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        mirror.write_reg(idx, data);
    endtask

    task automatic apply_setting(logic [MAC_W-1:0] mac, logic valid);
        settle();
        write_reg(CFG_MAC, mac);
        write_reg(CFG_MAC_VALID, {{(MAC_W-1){1'b0}}, valid});
        ctrl_mac = mac;
        settings_used++;
    endtask

    task automatic run_directed();
        drive_request(make_req(REQ_GET, '0, '0, '0, '0, '0, '1), 0);
        drive_request(make_req(REQ_FIND, '0, '0, '0, '0, '0, '0), 2);
        drive_request(make_req(REQ_UPSERT, '0, 8'h00, 8'h00, 8'h00, '0, '0), 0);
        drive_request(make_req(REQ_UPSERT, '1, 8'hff, 8'hff, 8'hff, '1, '1), 16);
        drive_request(make_req(REQ_UPSERT, '0, 8'h5a, 8'ha5, 8'h3c, 48'h1, '0), 0);
        drive_request(make_req(REQ_GET, '0, '0, '0, '0, '0, 4'd0), 1);
        drive_request(make_req(REQ_GET, '0, '0, '0, '0, '0, 4'd1), 0);
        // fill the remaining slots, then overflow
        for (int k = 0; k < TABLE_DEPTH - 2; k++)
            drive_request(make_req(REQ_UPSERT, rand_mac(), 8'($urandom), 8'($urandom),
                                   8'($urandom), pick_owner(rand_mac()), '0),
                          $urandom_range(0, 3));
        drive_request(make_req(REQ_UPSERT, rand_mac(), 8'h11, 8'h22, 8'h33, '1, '0), 0);
        drive_request(make_req(REQ_UPSERT, '1, 8'h01, 8'h80, 8'h7f, '0, '0), 0);
        drive_request(make_req(REQ_FIND, '1, '0, '0, '0, '0, '0), 5);
        drive_request(make_req(REQ_CLEAR, '0, '0, '0, '0, '0, '0), 0);
        drive_request(make_req(REQ_GET, '0, '0, '0, '0, '0, 4'd0), 0);
    endtask

    task automatic run_random(int n);
        logic [MAC_W-1:0] pool [POOL_SIZE];
        request_t         rq;
        int               roll;
        bit               bursting;
        pool[0] = '0;
        pool[1] = '1;
        pool[2] = ctrl_mac;
        for (int i = 3; i < POOL_SIZE; i++)
            pool[i] = rand_mac();
        bursting = 1'($urandom_range(0, 1));
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 39) == 0)
                bursting = !bursting;
            roll = $urandom_range(0, 99);
            if (roll < 45)
                rq.kind = REQ_UPSERT;
            else if (roll < 70)
                rq.kind = REQ_FIND;
            else if (roll < 97)
                rq.kind = REQ_GET;
            else
                rq.kind = REQ_CLEAR;
            rq.peer = ($urandom_range(0, 6) == 0) ? rand_mac() :
                      pool[$urandom_range(0, POOL_SIZE - 1)];
            rq.active_profile = 8'($urandom);
            rq.default_profile = 8'($urandom);
            rq.dev_state = 8'($urandom);
            rq.owner = pick_owner(pool[$urandom_range(0, POOL_SIZE - 1)]);
            rq.index = 4'($urandom);
            drive_request(rq, bursting ? 0 : $urandom_range(0, 16));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        apply_setting('1, 1'b1);
        run_random(PHASE_ITEMS);
        apply_setting(rand_mac(), 1'b1);
        run_random(PHASE_ITEMS);
        apply_setting(rand_mac(), 1'b0);
        run_random(PHASE_ITEMS);
        apply_setting('0, 1'b1);
        run_random(PHASE_ITEMS);
        apply_setting(rand_mac(), 1'b1);
        run_random(PHASE_ITEMS);
        settle();
        repeat (24) @(posedge clk);
        $display("requests: %0d upserts, %0d finds, %0d gets, %0d clears",
                 mirror.n_upsert, mirror.n_find, mirror.n_get, mirror.n_clear);
        $display("%0d table-full and %0d miss replies over %0d controller settings, %0d errors",
                 mirror.n_full, mirror.n_miss, settings_used, mirror.errors);
        if (mirror.errors == 0 && mirror.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
